@@ rtl/core/hkdv_pkg.sv @@
// ----------------------------------------------------------------------------
// hkdv_pkg
// shared types, constants and character helpers for the hex key decoder
// ----------------------------------------------------------------------------
package hkdv_pkg;

    localparam int PREFIX_MAX_BYTES_DEF = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W = 1;
    localparam int PREFIX_LEN_W = 4;

    localparam logic [CFG_DATA_W-1:0] PREFIX_BYTES_RST = 64'h0000_002E_7265_7375;
    localparam logic [PREFIX_LEN_W-1:0] PREFIX_LEN_RST = 4'd5;

    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = 1'd1;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_DOT = 8'h2E;

    typedef struct packed {
        logic [7:0] key_char;
        logic       key_last;
    } in_item_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] decoded_byte;
        logic       in_local_part;
        logic       key_done;
        logic       accepted;
    } out_item_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok = 1'b1;
        d.value = 4'd0;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
        begin
            d.value = 4'(c - CH_DIGIT_0);
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            d.value = 4'(c - CH_LOWER_A + 8'd10);
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            d.value = 4'(c - CH_UPPER_A + 8'd10);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic logic is_start_char(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_UNDERSCORE;
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_start_char(c) || (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
               c == CH_DASH || c == CH_DOT;
    endfunction

endpackage

@@ rtl/core/hex_key_decoder_validator_top.sv @@
// ----------------------------------------------------------------------------
// hex_key_decoder_validator_top
// checks a configured key prefix, hex-decodes namespace and local-name bytes
// and validates the local name, one key character per item
// ----------------------------------------------------------------------------
//  channel | signals                          | handshake
//  --------+----------------------------------+-------------------------------
//  in      | in_data (key_char, key_last)     | in_valid / in_ready
//  out     | out_data (byte, flags, verdict)  | out_valid / out_ready
//  cfg     | cfg_index, cfg_data              | cfg_we, no wait
//
//  one character per cycle while in_ready is high: key state updates in the
//  cycle an item is taken; byte and key-end results register on the same edge
//  in_ready stays high while the output register is empty or being drained,
//  so a stalled output holds back at most one item
//  reset restores the default prefix "user." and clears the key state
// ----------------------------------------------------------------------------
module hex_key_decoder_validator_top #(
    parameter int PREFIX_MAX_BYTES = hkdv_pkg::PREFIX_MAX_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  hkdv_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output hkdv_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [hkdv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hkdv_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hkdv_pkg::*;

    localparam int POS_W = $clog2(PREFIX_MAX_BYTES + 1);
    localparam int IDX_W = (PREFIX_MAX_BYTES > 1) ? $clog2(PREFIX_MAX_BYTES) : 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(PREFIX_MAX_BYTES);

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_NS     = 2'd1,
        PH_LOCAL  = 2'd2
    } phase_t;

    logic [7:0]              prefix_reg [PREFIX_MAX_BYTES];
    logic [PREFIX_LEN_W-1:0] prefix_len_reg;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       high_nibble_reg, high_nibble_next;
    logic             pending_reg, pending_next;
    logic             declined_reg, declined_next;
    logic             local_seen_reg, local_seen_next;
    logic             name_ended_reg, name_ended_next;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic             take;
    logic [POS_W-1:0] eff_len;
    phase_t           phase_cur;
    logic [7:0]       want;
    hex_digit_t       hd;
    logic             got_byte;
    logic [7:0]       dec_byte;
    out_item_t        res;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // saturate the configured length
    assign eff_len = (prefix_len_reg > PREFIX_LEN_W'(PREFIX_MAX_BYTES)) ?
                     POS_MAX : POS_W'(prefix_len_reg);

    always_comb
    begin
        phase_cur = phase_reg;
        if (phase_reg == PH_PREFIX && pos_reg >= eff_len)
        begin
            phase_cur = PH_NS;
        end

        want = prefix_reg[pos_reg[IDX_W-1:0]];
        hd = hex_decode(in_data.key_char);
        dec_byte = {high_nibble_reg, hd.value};

        phase_next = phase_cur;
        pos_next = pos_reg;
        high_nibble_next = high_nibble_reg;
        pending_next = pending_reg;
        declined_next = declined_reg;
        local_seen_next = local_seen_reg;
        name_ended_next = name_ended_reg;
        got_byte = 1'b0;

        if (declined_reg)
        begin
            // wait for the end of the key
        end
        else
        begin
            unique case (phase_cur)
                PH_PREFIX:
                begin
                    if (in_data.key_char != want)
                    begin
                        declined_next = 1'b1;
                    end
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg + 1'b1 >= eff_len)
                    begin
                        phase_next = PH_NS;
                    end
                end
                PH_NS, PH_LOCAL:
                begin
                    if (phase_cur == PH_NS && in_data.key_char == CH_DOT)
                    begin
                        if (pending_reg)
                        begin
                            declined_next = 1'b1;
                        end
                        pending_next = 1'b0;
                        high_nibble_next = 4'd0;
                        phase_next = PH_LOCAL;
                    end
                    else if (!hd.ok)
                    begin
                        declined_next = 1'b1;
                    end
                    else if (!pending_reg)
                    begin
                        high_nibble_next = hd.value;
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        got_byte = 1'b1;
                        pending_next = 1'b0;
                        high_nibble_next = 4'd0;
                        // local name check, stops at a zero byte
                        if (phase_cur == PH_LOCAL && !name_ended_reg)
                        begin
                            if (dec_byte == 8'd0)
                            begin
                                name_ended_next = 1'b1;
                                if (!local_seen_reg)
                                begin
                                    declined_next = 1'b1;
                                end
                            end
                            else if (!local_seen_reg)
                            begin
                                if (!is_start_char(dec_byte))
                                begin
                                    declined_next = 1'b1;
                                end
                                local_seen_next = 1'b1;
                            end
                            else if (!is_name_char(dec_byte))
                            begin
                                declined_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    declined_next = 1'b1;
                end
            endcase
        end

        res.byte_valid    = got_byte;
        res.decoded_byte  = got_byte ? dec_byte : 8'd0;
        res.in_local_part = got_byte && (phase_cur == PH_LOCAL);
        res.key_done      = in_data.key_last;
        res.accepted      = in_data.key_last && !declined_next && phase_next == PH_LOCAL &&
                            !pending_next && local_seen_next;

        if (in_data.key_last)
        begin
            phase_next = PH_PREFIX;
            pos_next = '0;
            high_nibble_next = 4'd0;
            pending_next = 1'b0;
            declined_next = 1'b0;
            local_seen_next = 1'b0;
            name_ended_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PREFIX_MAX_BYTES; i++)
            begin
                prefix_reg[i] <= PREFIX_BYTES_RST[i*8 +: 8];
            end
            prefix_len_reg <= PREFIX_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PREFIX_BYTES:
                begin
                    for (int i = 0; i < PREFIX_MAX_BYTES; i++)
                    begin
                        prefix_reg[i] <= cfg_data[i*8 +: 8];
                    end
                end
                REG_PREFIX_LENGTH:
                begin
                    prefix_len_reg <= cfg_data[PREFIX_LEN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            pos_reg <= '0;
            high_nibble_reg <= 4'd0;
            pending_reg <= 1'b0;
            declined_reg <= 1'b0;
            local_seen_reg <= 1'b0;
            name_ended_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                pos_reg <= pos_next;
                high_nibble_reg <= high_nibble_next;
                pending_reg <= pending_next;
                declined_reg <= declined_next;
                local_seen_reg <= local_seen_next;
                name_ended_reg <= name_ended_next;
            end
            if (take && (got_byte || in_data.key_last))
            begin
                out_valid_reg <= 1'b1;
                out_data_reg <= res;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
